// ===== src/sst_pkg.sv =====
// Shared types, codes and sizes for the slot schedule timer.
// Used by every module of the block; depends on nothing.
package sst_pkg;

  // queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = QAW + 1;

  // result buffer sizing (two results may be written per cycle)
  localparam int OBUF_DEPTH  = 4;
  localparam int OBUF_AW     = $clog2(OBUF_DEPTH);
  localparam int OBUF_CW     = OBUF_AW + 1;

  // stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;

  // register indexes
  localparam logic [1:0] CFG_TIMER_MODE     = 2'd0;
  localparam logic [1:0] CFG_PERIOD_TICKS   = 2'd1;
  localparam logic [1:0] CFG_RESERVED_TICKS = 2'd2;

  // opcodes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_KILL    = 2'd2;

  // timer modes
  localparam logic [1:0] MODE_ONESHOT  = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_SLOT     = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_EXPIRY = 2'd0;
  localparam logic [1:0] KIND_CHECK  = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  // input word, opcode in the lowest bits
  typedef struct packed {
    logic [7:0]  check_flag;
    logic [15:0] node_id;
    logic [15:0] slot_ticks;
    logic        has_slot;
    logic [1:0]  opcode;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  // configuration registers
  typedef struct packed {
    logic [1:0]  timer_mode;
    logic [15:0] period_ticks;
    logic [15:0] reserved_ticks;
  } cfg_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic        killed;
    logic [7:0]  check_value;
    logic [31:0] tick_stamp;
    logic        last;
  } result_t;

  // results of one item, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

endpackage

// ===== src/sst_in_reg.sv =====
// Input register stage of the slot schedule timer.
// Holds one accepted word until the engine takes it; uses sst_pkg.
module sst_in_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sst_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            take,
  output logic                            item_valid,
  output sst_pkg::item_t                  item
);

  logic           valid_r, valid_nxt;
  sst_pkg::item_t item_r;

  // accept when empty or when the held word leaves this cycle
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  // hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // capture the payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= sst_pkg::item_t'(in_tdata[sst_pkg::ITEM_W-1:0]);
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== src/sst_engine.sv =====
// Timer state, slot queue and per-word step logic of the slot schedule timer.
// Turns one word into up to two results in the cycle that it takes the word; uses sst_pkg.
module sst_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  sst_pkg::item_t     item,
  input  logic               out_space,
  input  sst_pkg::cfg_t      cfg,
  output logic               take,
  output sst_pkg::res_pair_t res
);

  // timer state
  logic                      running_r, running_nxt;
  logic [15:0]               remaining_r, remaining_nxt;
  logic [31:0]               tick_r, tick_nxt;
  logic [sst_pkg::QAW-1:0]   head_r, head_nxt;
  logic [sst_pkg::QAW-1:0]   tail_r, tail_nxt;
  logic [sst_pkg::OCC_W-1:0] occ_r, occ_nxt;

  // slot storage, undefined until written
  logic [15:0] q_len [sst_pkg::QUEUE_DEPTH];
  logic [7:0]  q_chk [sst_pkg::QUEUE_DEPTH];
  logic        q_we;

  logic [sst_pkg::QAW-1:0] head_inc, tail_inc, rd_idx;
  logic [15:0]             rd_len;
  logic [7:0]              rd_chk;
  logic [15:0]             rem_dec;
  logic [31:0]             ts;
  logic                    all_zero, q_full;

  // pointer wrap
  assign head_inc = (head_r == sst_pkg::QAW'(sst_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == sst_pkg::QAW'(sst_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : tail_r + 1'b1;

  // the next slot follows a pop on expiry, else the current head
  assign rd_idx = (item.opcode == sst_pkg::OP_TICK && occ_r != '0) ? head_inc : head_r;
  assign rd_len = q_len[rd_idx];
  assign rd_chk = q_chk[rd_idx];

  assign take     = item_valid && out_space;
  assign rem_dec  = (remaining_r != '0) ? remaining_r - 1'b1 : '0;
  assign ts       = (item.opcode == sst_pkg::OP_TICK) ? tick_r + 1'b1 : tick_r;
  assign all_zero = (item.slot_ticks == '0) && (item.node_id == '0) &&
                    (item.check_flag == '0);
  assign q_full   = (occ_r == sst_pkg::OCC_W'(sst_pkg::QUEUE_DEPTH));

  // step one word
  always_comb begin
    logic [sst_pkg::OCC_W-1:0] occ_p;
    logic [15:0]               len_s;
    logic [7:0]                chk_s;
    logic [15:0]               slot_rem;
    logic                      start;
    running_nxt   = running_r;
    remaining_nxt = remaining_r;
    tick_nxt      = tick_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    q_we          = 1'b0;
    occ_p         = occ_r;
    start         = 1'b0;
    len_s         = rd_len;
    chk_s         = rd_chk;
    res.cnt       = 2'd0;
    res.r0        = '{kind: sst_pkg::KIND_EXPIRY, killed: 1'b0, check_value: 8'd0,
                      tick_stamp: ts, last: 1'b0};
    res.r1        = res.r0;

    case (item.opcode)
      sst_pkg::OP_TICK: begin
        tick_nxt = tick_r + 1'b1;
        if (running_r) begin
          remaining_nxt = rem_dec;
          if (rem_dec == '0) begin
            res.cnt = 2'd1;
            case (cfg.timer_mode)
              sst_pkg::MODE_SLOT: begin
                // pop the finished slot, then start the next or announce the end
                if (occ_r != '0) begin
                  occ_p    = occ_r - 1'b1;
                  head_nxt = head_inc;
                end
                occ_nxt = occ_p;
                res.cnt = 2'd2;
                res.r1.kind = sst_pkg::KIND_CHECK;
                if (occ_p != '0) begin
                  start = 1'b1;
                end else begin
                  running_nxt = 1'b0;
                end
              end
              sst_pkg::MODE_PERIODIC: begin
                remaining_nxt = cfg.period_ticks;
              end
              default: begin
                running_nxt = 1'b0;
              end
            endcase
          end
        end
      end
      sst_pkg::OP_TRIGGER: begin
        if (cfg.timer_mode == sst_pkg::MODE_ONESHOT ||
            cfg.timer_mode == sst_pkg::MODE_PERIODIC) begin
          if (!running_r) begin
            running_nxt   = 1'b1;
            remaining_nxt = cfg.period_ticks;
          end
        end else if (cfg.timer_mode == sst_pkg::MODE_SLOT && item.has_slot) begin
          if (all_zero) begin
            // clear the schedule, ending a running slot
            head_nxt = '0;
            tail_nxt = '0;
            occ_nxt  = '0;
            if (running_r) begin
              running_nxt    = 1'b0;
              res.cnt        = 2'd2;
              res.r0.killed  = 1'b1;
              res.r1.kind    = sst_pkg::KIND_CHECK;
            end
          end else begin
            if (q_full) begin
              res.cnt     = 2'd1;
              res.r0.kind = sst_pkg::KIND_DROP;
            end else begin
              q_we     = 1'b1;
              tail_nxt = tail_inc;
              occ_p    = occ_r + 1'b1;
              occ_nxt  = occ_p;
            end
            // an idle timer starts the head slot; a fresh push into an
            // empty queue is the head itself
            if (!running_r && occ_p != '0) begin
              start = 1'b1;
              if (occ_r == '0) begin
                len_s = item.slot_ticks;
                chk_s = item.check_flag;
              end
              if (q_full) begin
                res.cnt     = 2'd2;
                res.r1.kind = sst_pkg::KIND_CHECK;
              end else begin
                res.cnt     = 2'd1;
                res.r0.kind = sst_pkg::KIND_CHECK;
              end
            end
          end
        end
      end
      sst_pkg::OP_KILL: begin
        if (running_r) begin
          running_nxt   = 1'b0;
          res.cnt       = 2'd1;
          res.r0.killed = 1'b1;
          if (cfg.timer_mode == sst_pkg::MODE_SLOT) begin
            head_nxt    = '0;
            tail_nxt    = '0;
            occ_nxt     = '0;
            res.cnt     = 2'd2;
            res.r1.kind = sst_pkg::KIND_CHECK;
          end
        end
      end
      default: begin
      end
    endcase

    // start a slot: reserved time off, floored at zero, and announce it
    slot_rem = (len_s > cfg.reserved_ticks) ? len_s - cfg.reserved_ticks : '0;
    if (start) begin
      running_nxt   = 1'b1;
      remaining_nxt = slot_rem;
      if (res.cnt == 2'd2) begin
        res.r1.check_value = chk_s;
      end else begin
        res.r0.check_value = chk_s;
      end
    end

    // mark the final result
    if (res.cnt == 2'd1) begin
      res.r0.last = 1'b1;
    end else if (res.cnt == 2'd2) begin
      res.r1.last = 1'b1;
    end

    if (!take) begin
      res.cnt = 2'd0;
    end
  end

  // advance the timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      remaining_r <= '0;
      tick_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
    end else if (take) begin
      running_r   <= running_nxt;
      remaining_r <= remaining_nxt;
      tick_r      <= tick_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
    end
  end

  // write a pushed slot at the tail
  always_ff @(posedge clk) begin
    if (take && q_we) begin
      q_len[tail_r] <= item.slot_ticks;
      q_chk[tail_r] <= item.check_flag;
    end
  end

endmodule

// ===== src/sst_out_fifo.sv =====
// Result buffer of the slot schedule timer: takes up to two results a cycle
// and hands out one word a cycle on the output stream while out_tready is high; uses sst_pkg.
module sst_out_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sst_pkg::res_pair_t               res,
  output logic                             space,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sst_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [sst_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tlast
);

  sst_pkg::result_t buf_q [sst_pkg::OBUF_DEPTH];

  logic [sst_pkg::OBUF_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_inc;
  logic [sst_pkg::OBUF_CW-1:0] cnt_r, cnt_nxt;
  logic                        pop;
  sst_pkg::result_t            head;

  assign space  = (cnt_r <= sst_pkg::OBUF_CW'(sst_pkg::OBUF_DEPTH - 2));
  assign pop    = out_tvalid && out_tready;
  assign wr_inc = wr_r + 1'b1;

  always_comb begin
    wr_nxt  = wr_r + sst_pkg::OBUF_AW'(res.cnt);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + sst_pkg::OBUF_CW'(res.cnt) - sst_pkg::OBUF_CW'(pop);
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store the results in order
  always_ff @(posedge clk) begin
    if (res.cnt != 2'd0) begin
      buf_q[wr_r] <= res.r0;
    end
    if (res.cnt == 2'd2) begin
      buf_q[wr_inc] <= res.r1;
    end
  end

  assign head       = buf_q[rd_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {head.tick_stamp, head.check_value};
  assign out_tuser  = {head.killed, head.kind};
  assign out_tlast  = head.last;

endmodule

// ===== src/slot_schedule_timer_core.sv =====
// Slot schedule timer: one-shot, periodic and queued slot countdowns on ticks.
// Path: input register, then the engine, then the result buffer to out_.
// Throughput: one input word per cycle while the result buffer has space;
// results leave one word per cycle while out_tready is high (4-entry buffer).
// Reset (rst_n low, synchronous) stops the timer, empties queue and buffer and
// zeroes the tick count and registers; slot storage holds stale data, unread.
module slot_schedule_timer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: opcode[1:0], has_slot[2], slot_ticks[18:3], node_id[34:19],
  // check_flag[42:35], zero[47:43]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sst_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: check_value[7:0], tick_stamp[39:8]
  // out_tuser: kind[1:0], killed[2]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sst_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [sst_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_wdata
);

  sst_pkg::cfg_t      cfg_r, cfg_nxt;
  sst_pkg::item_t     item;
  sst_pkg::res_pair_t res;
  logic               item_valid, take, space;

  // decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sst_pkg::CFG_TIMER_MODE:     cfg_nxt.timer_mode     = cfg_wdata[1:0];
        sst_pkg::CFG_PERIOD_TICKS:   cfg_nxt.period_ticks   = cfg_wdata;
        sst_pkg::CFG_RESERVED_TICKS: cfg_nxt.reserved_ticks = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sst_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  sst_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_space  (space),
    .cfg        (cfg_r),
    .take       (take),
    .res        (res)
  );

  sst_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
